/* rtl/frame_difference_motion_metric_core_macros.svh */
// Assertion helpers shared by the core
`ifndef FRAME_DIFFERENCE_MOTION_METRIC_CORE_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_METRIC_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define FDMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FDMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fdmm_pkg.sv */
package fdmm_pkg;

    localparam int PIXEL_W    = 8;
    localparam int DIM_W      = 11;
    localparam int MEAN_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    // Register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One quotient bit per divider step
    localparam int DIV_STEPS = MEAN_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic pixel;
        logic restart;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic ref_valid;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/fdmm_ram.sv */
module fdmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write at one address return the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fdmm_ctrl.sv */
module fdmm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_kind,
    input  logic                 i_cfg_write,
    input  fdmm_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output fdmm_pkg::t_dp_cmd    o_cmd
);

    import fdmm_pkg::*;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_ACC = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_settle;
    t_dp_cmd           cmd;
    logic              stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        stall   = 1'b1;
        case (r_state)
            ST_RUN: begin
                // hold requests in the cycle after a register write
                stall = r_settle;
                if (i_in_valid && !r_settle) begin
                    if (i_kind == KIND_RESTART) begin
                        cmd.restart = 1'b1;
                    end else begin
                        cmd.pixel = 1'b1;
                        if (i_status.last) begin
                            n_state = ST_ACC;
                        end
                    end
                end
            end
            ST_ACC: begin
                cmd.div_load = 1'b1;
                n_step       = '0;
                n_state      = i_status.ref_valid ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                n_step       = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_step   <= '0;
            r_settle <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_settle <= i_cfg_write;
        end
    end

    assign o_in_stall = stall;
    assign o_cmd      = cmd;

endmodule

/* rtl/fdmm_dp.sv */
module fdmm_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fdmm_pkg::t_dp_cmd              i_cmd,
    input  logic [fdmm_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic [fdmm_pkg::DIM_W-1:0]     i_frame_width,
    input  logic [fdmm_pkg::DIM_W-1:0]     i_frame_height,
    input  logic                           i_out_stall,
    output fdmm_pkg::t_dp_status           o_status,
    output logic                           o_out_valid,
    output logic [fdmm_pkg::MEAN_W-1:0]    o_mean_diff,
    output logic                           o_has_reference,
    output logic [fdmm_pkg::COUNT_W-1:0]   o_frame_count
);

    import fdmm_pkg::*;

    localparam int MAXN   = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W  = $clog2(MAXN + 1);
    localparam int ADDR_W = (MAXN > 1) ? $clog2(MAXN) : 1;
    localparam int SUM_W  = PIX_W + PIXEL_W;
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HT_W   = $clog2(MAX_HEIGHT + 1);

    logic [WD_W-1:0]    width_c;
    logic [HT_W-1:0]    height_c;
    logic [PIX_W-1:0]   r_prod;
    logic [PIX_W-1:0]   r_frame_n;
    logic [PIX_W-1:0]   frame_n_eff;
    logic [ADDR_W-1:0]  r_pos;
    logic               last;
    logic               r_ref_valid;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] count_inc;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [SUM_W-1:0]   sum_base;
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_px;
    logic [PIXEL_W-1:0] old_px;
    logic [PIXEL_W-1:0] abs_diff;
    logic [PIX_W-1:0]   r_rem;
    logic [MEAN_W-1:0]  r_dvd_lo;
    logic [MEAN_W-1:0]  r_quo;
    logic [PIX_W:0]     trial;
    logic [PIX_W:0]     trial_sub;
    logic               trial_ge;
    logic               out_free;
    logic               r_out_valid;
    logic [MEAN_W-1:0]  r_out_mean;
    logic               r_out_ref;
    logic [COUNT_W-1:0] r_out_count;

    // Zero counts as one, oversize saturates
    always_comb begin
        if (i_frame_width == '0) begin
            width_c = WD_W'(1);
        end else if (32'(i_frame_width) > 32'(MAX_WIDTH)) begin
            width_c = WD_W'(MAX_WIDTH);
        end else begin
            width_c = WD_W'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            height_c = HT_W'(1);
        end else if (32'(i_frame_height) > 32'(MAX_HEIGHT)) begin
            height_c = HT_W'(MAX_HEIGHT);
        end else begin
            height_c = HT_W'(i_frame_height);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PIX_W'(PIX_W'(width_c) * PIX_W'(height_c));
    end

    assign frame_n_eff = (r_pos == '0) ? r_prod : r_frame_n;
    assign last        = (PIX_W'(r_pos) + PIX_W'(1)) == frame_n_eff;

    fdmm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAXN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pixel),
        .i_waddr (r_pos),
        .i_wdata (i_pixel),
        .i_re    (i_cmd.pixel),
        .i_raddr (r_pos),
        .o_rdata (old_px)
    );

    assign abs_diff = (r_s1_px > old_px) ? (r_s1_px - old_px) : (old_px - r_s1_px);

    always_comb begin
        sum_base = (i_cmd.pixel && (r_pos == '0)) ? '0 : r_sum;
        n_sum    = sum_base;
        if (r_s1_valid && r_ref_valid) begin
            n_sum = sum_base + SUM_W'(abs_diff);
        end
    end

    assign count_inc = (r_count == COUNT_MAX) ? r_count : (r_count + COUNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_ref_valid <= 1'b0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
        end else if (i_cmd.restart) begin
            // drop the partial frame and the pixel still in flight
            r_pos       <= '0;
            r_sum       <= '0;
            r_ref_valid <= 1'b0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.pixel;
            r_sum      <= n_sum;
            if (i_cmd.pixel) begin
                r_pos <= last ? '0 : (r_pos + ADDR_W'(1));
            end
            if (i_cmd.out_load) begin
                r_ref_valid <= 1'b1;
                if (r_ref_valid) begin
                    r_count <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pixel) begin
            r_s1_px <= i_pixel;
            if (r_pos == '0) begin
                r_frame_n <= r_prod;
            end
        end
    end

    // Restoring division of sum*256 by the pixel count, one quotient bit a step
    assign trial     = {r_rem, r_dvd_lo[MEAN_W-1]};
    assign trial_sub = trial - {1'b0, r_frame_n};
    assign trial_ge  = trial >= {1'b0, r_frame_n};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem    <= PIX_W'(n_sum >> PIXEL_W);
            r_dvd_lo <= {n_sum[PIXEL_W-1:0], {(MEAN_W - PIXEL_W){1'b0}}};
            r_quo    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem    <= trial_ge ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
            r_dvd_lo <= {r_dvd_lo[MEAN_W-2:0], 1'b0};
            r_quo    <= {r_quo[MEAN_W-2:0], trial_ge};
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_mean  <= r_ref_valid ? r_quo : '0;
            r_out_ref   <= r_ref_valid;
            r_out_count <= r_ref_valid ? count_inc : r_count;
        end
    end

    assign o_status.last      = last;
    assign o_status.ref_valid = r_ref_valid;
    assign o_status.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_mean_diff     = r_out_mean;
    assign o_has_reference = r_out_ref;
    assign o_frame_count   = r_out_count;

endmodule

/* rtl/frame_difference_motion_metric_core.sv */
// Pixels are taken one per cycle inside a frame unless stalled; the store read runs one
// stage behind. After a frame's last pixel an accumulate state, 16 divider steps
// (skipped without a reference) and an output load yield the result; input stalls
// meanwhile, while a held result blocks the load, and in the cycle after a register write.
// Synchronous active-low reset clears control state and sets width 640, height 480;
// the previous-frame store is not cleared.
`include "frame_difference_motion_metric_core_macros.svh"

module frame_difference_motion_metric_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fdmm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fdmm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fdmm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [fdmm_pkg::PIXEL_W-1:0]      i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fdmm_pkg::MEAN_W-1:0]       o_mean_diff,
    output logic                              o_has_reference,
    output logic [fdmm_pkg::COUNT_W-1:0]      o_frame_count
);

    import fdmm_pkg::*;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic             cfg_write;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    fdmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_cfg_write (cfg_write),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    fdmm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_pixel         (i_pixel),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .i_out_stall     (i_out_stall),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_mean_diff     (o_mean_diff),
        .o_has_reference (o_has_reference),
        .o_frame_count   (o_frame_count)
    );

    `FDMM_ASSERT_NEXT(a_cfg_settle, i_clk, i_rst_n, cfg_write, o_in_stall, "request taken right after a register write")
    `FDMM_ASSERT_SAME(a_div_stall, i_clk, i_rst_n, w_cmd.div_step, o_in_stall, "request taken while dividing")
    `FDMM_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_cmd.out_load, o_out_valid, "result load lost")
    `FDMM_ASSERT_SAME(a_no_ref_zero, i_clk, i_rst_n, (o_out_valid && !o_has_reference), ((o_mean_diff == '0) && (o_frame_count == '0)), "unmeasured frame with nonzero result")

endmodule
